### sv/vbsp_pkg.sv
// Shared types and constants for the vector beam slew and power ramp block.
`timescale 1ns / 1ps

package vbsp_pkg;

    // Fixed field widths
    localparam int TIME_WIDTH     = 16;
    localparam int SPEED_WIDTH    = 24;
    localparam int RATE_WIDTH     = 18;
    localparam int STEP_WIDTH     = 24;
    localparam int POWER_WIDTH    = 15;
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 24;

    // Configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SLEW_SPEED = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RAMP_UP    = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RAMP_DOWN  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_SQX,
        ST_SQY,
        ST_SQS,
        ST_DELTA,
        ST_POWER,
        ST_ROOT,
        ST_DIVX,
        ST_WAITX,
        ST_DIVY,
        ST_WAITY,
        ST_DONE
    } vbsp_state_t;

    // Root/divide unit operation
    typedef enum logic {
        SD_SQRT,
        SD_DIV
    } vbsp_sd_mode_t;

    typedef struct packed {
        logic          start;
        vbsp_sd_mode_t mode;
    } vbsp_sd_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vbsp_sd_sts_t;

endpackage

### sv/vbsp_sqdiv.sv
// Iterative square root / restoring divider sharing one subtractor.
`timescale 1ns / 1ps

module vbsp_sqdiv #(
    parameter int SQ_BITS  = 22,
    parameter int DIV_BITS = 21,
    parameter int DVW      = 24,
    parameter int NUM_W    = 45,
    parameter int RES_W    = 22
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vbsp_pkg::vbsp_sd_req_t req,
    input  logic [NUM_W-1:0]       operand,
    input  logic [DVW-1:0]         divisor,
    output vbsp_pkg::vbsp_sd_sts_t sts,
    output logic [RES_W-1:0]       result
);
    import vbsp_pkg::*;

    localparam int UW      = ((SQ_BITS + 3) > (DVW + 1)) ? (SQ_BITS + 3) : (DVW + 1);
    localparam int MAXIT   = (SQ_BITS > DIV_BITS) ? SQ_BITS : DIV_BITS;
    localparam int CNTW    = $clog2(MAXIT + 1);
    localparam int SQ_IN_W = 2 * SQ_BITS;

    logic                busy_reg, done_reg;
    vbsp_sd_mode_t       mode_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [UW-1:0]       rem_reg;
    logic [RES_W-1:0]    res_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DVW-1:0]      dvs_reg;

    logic [UW-1:0]       cand, trial, rem_step;
    logic [UW:0]         diff;
    logic                ge;
    logic [NUM_W-1:0]    num_step;

    // One digit per cycle: bring down bits, trial subtract, keep or restore
    always_comb begin
        if (mode_reg == SD_SQRT) begin
            cand     = {rem_reg[UW-3:0], num_reg[NUM_W-1 -: 2]};
            trial    = UW'({res_reg, 2'b01});
            num_step = num_reg << 2;
        end else begin
            cand     = {rem_reg[UW-2:0], num_reg[NUM_W-1]};
            trial    = UW'(dvs_reg);
            num_step = num_reg << 1;
        end
        diff     = {1'b0, cand} - {1'b0, trial};
        ge       = ~diff[UW];
        rem_step = ge ? diff[UW-1:0] : cand;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.mode;
            res_reg  <= '0;
            dvs_reg  <= divisor;
            if (req.mode == SD_SQRT) begin
                cnt_reg <= CNTW'(SQ_BITS);
                rem_reg <= '0;
                num_reg <= operand << (NUM_W - SQ_IN_W);
            end else begin
                cnt_reg <= CNTW'(DIV_BITS);
                rem_reg <= UW'(operand >> DIV_BITS);
                num_reg <= operand << (NUM_W - DIV_BITS);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNTW'(1);
            rem_reg <= rem_step;
            res_reg <= {res_reg[RES_W-2:0], ge};
            num_reg <= num_step;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = res_reg;

endmodule

### sv/vector_beam_slew_and_power_ramp.sv
// Top level: beam slew toward target and beam power ramp, one result per tick.
`timescale 1ns / 1ps

// Usage:
//   Input stream (s_*): one transaction per tick. s_tdata carries target_x,
//   target_y and elapsed; s_tuser carries beam_on. Output stream (m_*): one
//   transaction per tick with the new beam position, power and moving flag.
//   Configuration: cfg_wr_en/cfg_addr/cfg_wr_data write slew_speed (0),
//   ramp_up_rate (1) and ramp_down_rate (2); write only while idle.
// Sequencing:
//   One tick at a time. A tick whose beam does not move, or snaps to the
//   target, is timed by the bit-pair square root of the shared root/divide
//   unit. A partial move adds two divisions of COORD_WIDTH+1 steps each.
//   s_tready is high only while the sequencer is idle.
// Reset:
//   aresetn (synchronous) clears the position, power, registers and m_tvalid.
// Stalls:
//   A finished result waits in the output register; the next tick is taken
//   meanwhile and its result waits in the sequencer until m_tready.
module vector_beam_slew_and_power_ramp #(
    parameter int COORD_WIDTH = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: target_x, target_y, elapsed (low to high), zero padded
    input  logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] s_tdata,
    // tuser: beam_on
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: beam_x, beam_y, power_level (low to high), zero padded
    output logic [((2*COORD_WIDTH+15+7)/8)*8-1:0] m_tdata,
    // tuser: moving
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [vbsp_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [vbsp_pkg::CFG_DATA_WIDTH-1:0] cfg_wr_data
);
    import vbsp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int SW    = (DW > 31) ? 31 : DW;
    localparam int RTW   = SW + 1;
    localparam int D2W   = 2 * RTW;
    localparam int DSW   = RTW + 2;
    localparam int MA    = (DW > STEP_WIDTH) ? DW : STEP_WIDTH;
    localparam int MB    = (SW > STEP_WIDTH) ? SW : STEP_WIDTH;
    localparam int PRW   = MA + MB;
    localparam int NUMW  = (D2W > DW + STEP_WIDTH) ? D2W : (DW + STEP_WIDTH);
    localparam int RESW  = (RTW > DW) ? RTW : DW;
    localparam int PSW   = FRAC_BITS + 7;
    localparam int PPW   = ((PSW > RATE_WIDTH) ? PSW : RATE_WIDTH) + 1;
    localparam int OUT_W = 2 * CW + POWER_WIDTH;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam logic [PSW-1:0] POWER_MAX = PSW'(100 << FRAC_BITS);
    localparam logic [63:0]    NEAR_SQ   = 64'(9) << (2 * FRAC_BITS);
    localparam logic [63:0]    SH_LIMIT  = 64'h8000_0000;

    vbsp_state_t state_reg, state_next;

    // Configuration
    logic [SPEED_WIDTH-1:0] speed_reg;
    logic [RATE_WIDTH-1:0]  up_reg, down_reg;

    // Beam state
    logic [CW-1:0]  pos_x_reg, pos_y_reg;
    logic [PSW-1:0] power_reg;

    // Per-tick working registers
    logic [CW-1:0]         tx_reg, ty_reg;
    logic                  on_reg;
    logic [TIME_WIDTH-1:0] el_reg;
    logic [DW-1:0]         ax_reg, ay_reg;
    logic                  negx_reg, negy_reg;
    logic [1:0]            sh_reg;
    logic [SW-1:0]         sx_reg, sy_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [D2W-1:0]        d2_reg;
    logic [2*STEP_WIDTH-1:0] ss_reg;
    logic [DSW-1:0]        dist_reg;
    logic [PRW-1:0]        prod_reg;
    logic                  moving_reg;

    // Output register
    logic [CW-1:0]          out_x_reg, out_y_reg;
    logic [POWER_WIDTH-1:0] out_pw_reg;
    logic                   out_mv_reg;
    logic                   m_tvalid_reg;

    // Sequencer outputs
    logic          s_accept;
    logic          mul_en;
    logic [MA-1:0] a_op;
    logic [MB-1:0] b_op;
    vbsp_sd_req_t  sd_req;
    vbsp_sd_sts_t  sd_sts;
    logic [NUMW-1:0] sd_operand;
    logic [RESW-1:0] sd_result;
    logic          out_load;

    // Accept-time differences
    logic [CW-1:0] in_tx, in_ty;
    logic [DW-1:0] dx, dy, ax, ay;
    logic [1:0]    sh;

    // Root decision
    logic [RTW-1:0] root;
    logic [DSW-1:0] dist_val;
    logic           moving_now, reach, snap;

    // Approach results
    logic [DW-1:0] quot, new_x, new_y;

    // Power update
    logic [RATE_WIDTH-1:0] delta;
    logic [PPW-1:0]        pw_sum, pw_diff;
    logic [PSW-1:0]        power_next;

    assign s_accept = s_tvalid && s_tready;

    // Unpack input and form the magnitude of the target offset
    always_comb begin
        in_tx = s_tdata[CW-1:0];
        in_ty = s_tdata[2*CW-1:CW];
        dx = {in_tx[CW-1], in_tx} - {pos_x_reg[CW-1], pos_x_reg};
        dy = {in_ty[CW-1], in_ty} - {pos_y_reg[CW-1], pos_y_reg};
        ax = dx[DW-1] ? (DW'(0) - dx) : dx;
        ay = dy[DW-1] ? (DW'(0) - dy) : dy;
        sh = 2'd0;
        for (int s = 0; s < 2; s++) begin
            if (64'(ax >> sh) >= SH_LIMIT || 64'(ay >> sh) >= SH_LIMIT) begin
                sh = sh + 2'd1;
            end
        end
    end

    // Shared root/divide unit
    vbsp_sqdiv #(
        .SQ_BITS  (RTW),
        .DIV_BITS (DW),
        .DVW      (DSW),
        .NUM_W    (NUMW),
        .RES_W    (RESW)
    ) u_sqdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (sd_req),
        .operand  (sd_operand),
        .divisor  (dist_reg),
        .sts      (sd_sts),
        .result   (sd_result)
    );

    // Distance decisions once the root is known
    always_comb begin
        root = sd_result[RTW-1:0];
        dist_val = DSW'(root) << sh_reg;
        if (sh_reg == 2'd0) begin
            moving_now = 64'(d2_reg) >= NEAR_SQ;
            reach      = 64'(ss_reg) >= 64'(d2_reg);
        end else begin
            moving_now = 1'b1;
            reach      = 64'(step_reg) >= 64'(dist_val);
        end
        snap = reach || (dist_val == '0);
    end

    // Move each axis by the quotient toward the target
    always_comb begin
        quot  = sd_result[DW-1:0];
        new_x = negx_reg ? ({pos_x_reg[CW-1], pos_x_reg} - quot)
                         : ({pos_x_reg[CW-1], pos_x_reg} + quot);
        new_y = negy_reg ? ({pos_y_reg[CW-1], pos_y_reg} - quot)
                         : ({pos_y_reg[CW-1], pos_y_reg} + quot);
    end

    // Power ramp with saturation
    always_comb begin
        delta   = prod_reg[TIME_WIDTH +: RATE_WIDTH];
        pw_sum  = PPW'(power_reg) + PPW'(delta);
        pw_diff = PPW'(power_reg) - PPW'(delta);
        if (on_reg) begin
            power_next = (pw_sum > PPW'(POWER_MAX)) ? POWER_MAX : PSW'(pw_sum);
        end else begin
            power_next = (PPW'(delta) >= PPW'(power_reg)) ? '0 : PSW'(pw_diff);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_STEP;
            ST_STEP:  state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQS;
            ST_SQS:   state_next = ST_DELTA;
            ST_DELTA: state_next = ST_POWER;
            ST_POWER: state_next = ST_ROOT;
            ST_ROOT: begin
                if (sd_sts.done) begin
                    state_next = (!moving_now || snap) ? ST_DONE : ST_DIVX;
                end
            end
            ST_DIVX:  state_next = ST_WAITX;
            ST_WAITX: if (sd_sts.done) state_next = ST_DIVY;
            ST_DIVY:  state_next = ST_WAITY;
            ST_WAITY: if (sd_sts.done) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and unit requests
    always_comb begin
        s_tready     = 1'b0;
        mul_en       = 1'b0;
        a_op         = '0;
        b_op         = '0;
        sd_req.start = 1'b0;
        sd_req.mode  = SD_SQRT;
        sd_operand   = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_STEP: begin
                mul_en = 1'b1;
                a_op   = MA'(speed_reg);
                b_op   = MB'(el_reg);
            end
            ST_SQX: begin
                mul_en = 1'b1;
                a_op   = MA'(sx_reg);
                b_op   = MB'(sx_reg);
            end
            ST_SQY: begin
                mul_en = 1'b1;
                a_op   = MA'(sy_reg);
                b_op   = MB'(sy_reg);
            end
            ST_SQS: begin
                mul_en = 1'b1;
                a_op   = MA'(step_reg);
                b_op   = MB'(step_reg);
            end
            ST_DELTA: begin
                mul_en       = 1'b1;
                a_op         = on_reg ? MA'(up_reg) : MA'(down_reg);
                b_op         = MB'(el_reg);
                sd_req.start = 1'b1;
                sd_req.mode  = SD_SQRT;
                sd_operand   = NUMW'(d2_reg);
            end
            ST_ROOT: begin
                mul_en = sd_sts.done;
                a_op   = MA'(ax_reg);
                b_op   = MB'(step_reg);
            end
            ST_DIVX: begin
                mul_en       = 1'b1;
                a_op         = MA'(ay_reg);
                b_op         = MB'(step_reg);
                sd_req.start = 1'b1;
                sd_req.mode  = SD_DIV;
                sd_operand   = NUMW'(prod_reg);
            end
            ST_DIVY: begin
                sd_req.start = 1'b1;
                sd_req.mode  = SD_DIV;
                sd_operand   = NUMW'(prod_reg);
            end
            ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    // Control and beam state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            speed_reg    <= '0;
            up_reg       <= '0;
            down_reg     <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            power_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SLEW_SPEED: speed_reg <= cfg_wr_data[SPEED_WIDTH-1:0];
                    CFG_RAMP_UP:    up_reg    <= cfg_wr_data[RATE_WIDTH-1:0];
                    CFG_RAMP_DOWN:  down_reg  <= cfg_wr_data[RATE_WIDTH-1:0];
                    default:        speed_reg <= speed_reg;
                endcase
            end
            if (state_reg == ST_POWER) begin
                power_reg <= power_next;
            end
            if (state_reg == ST_ROOT && sd_sts.done && moving_now && snap) begin
                pos_x_reg <= tx_reg;
                pos_y_reg <= ty_reg;
            end
            if (state_reg == ST_WAITX && sd_sts.done) begin
                pos_x_reg <= new_x[CW-1:0];
            end
            if (state_reg == ST_WAITY && sd_sts.done) begin
                pos_y_reg <= new_y[CW-1:0];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tx_reg   <= in_tx;
            ty_reg   <= in_ty;
            on_reg   <= s_tuser;
            el_reg   <= s_tdata[2*CW +: TIME_WIDTH];
            ax_reg   <= ax;
            ay_reg   <= ay;
            negx_reg <= dx[DW-1];
            negy_reg <= dy[DW-1];
            sh_reg   <= sh;
            sx_reg   <= SW'(ax >> sh);
            sy_reg   <= SW'(ay >> sh);
        end
        if (mul_en) begin
            prod_reg <= PRW'(a_op) * PRW'(b_op);
        end
        if (state_reg == ST_SQX) begin
            step_reg <= prod_reg[TIME_WIDTH +: STEP_WIDTH];
        end
        if (state_reg == ST_SQY) begin
            d2_reg <= D2W'(prod_reg);
        end
        if (state_reg == ST_SQS) begin
            d2_reg <= d2_reg + D2W'(prod_reg);
        end
        if (state_reg == ST_DELTA) begin
            ss_reg <= prod_reg[2*STEP_WIDTH-1:0];
        end
        if (state_reg == ST_ROOT && sd_sts.done) begin
            dist_reg   <= dist_val;
            moving_reg <= moving_now;
        end
        if (out_load) begin
            out_x_reg  <= pos_x_reg;
            out_y_reg  <= pos_y_reg;
            out_pw_reg <= POWER_WIDTH'(power_reg);
            out_mv_reg <= moving_reg;
        end
    end

    assign m_tdata  = OUT_TW'({out_pw_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_mv_reg;
    assign m_tvalid = m_tvalid_reg;

    // Checks
    a_power_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        power_reg <= POWER_MAX)
        else $error("beam power above full scale");

    a_unit_busy_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sd_sts.busy |-> (state_reg == ST_POWER || state_reg == ST_ROOT ||
                         state_reg == ST_WAITX || state_reg == ST_WAITY))
        else $error("root/divide unit busy outside a wait state");

    a_still_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && sd_sts.done && !moving_now)
        |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("beam moved while inside the near zone");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

endmodule

### sim/vbsp_beam_checker.sv
// Beam position and power predictor that watches both streams and counts mismatches.
`timescale 1ns / 1ps

module vbsp_beam_checker #(
    parameter int COORD_WIDTH = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // tdata: target_x, target_y, elapsed (low to high), zero padded
    input  logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] s_tdata,
    // tuser: beam_on
    input  logic                                  s_tuser,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // tdata: beam_x, beam_y, power_level (low to high), zero padded
    input  logic [((2*COORD_WIDTH+15+7)/8)*8-1:0] m_tdata,
    // tuser: moving
    input  logic                                  m_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [vbsp_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [vbsp_pkg::CFG_DATA_WIDTH-1:0]   cfg_wr_data,
    output int                                    mismatches,
    output int                                    beams_pending
);
    import vbsp_pkg::*;

    localparam int     CW         = COORD_WIDTH;
    localparam longint NEAR_RAW   = longint'(3) << FRAC_BITS;
    localparam longint NEAR_SQ    = NEAR_RAW * NEAR_RAW;
    localparam longint POWER_FULL = longint'(100) << FRAC_BITS;

    typedef struct {
        logic signed [CW-1:0]    beam_x;
        logic signed [CW-1:0]    beam_y;
        logic                    moving;
        logic [POWER_WIDTH-1:0]  power_level;
    } beam_result_t;

    // Register copies
    logic [SPEED_WIDTH-1:0] slew_speed;
    logic [RATE_WIDTH-1:0]  ramp_up_rate;
    logic [RATE_WIDTH-1:0]  ramp_down_rate;

    // Beam state
    logic signed [CW-1:0]   pos_x;
    logic signed [CW-1:0]   pos_y;
    logic [POWER_WIDTH-1:0] power_store;

    beam_result_t pending_beams[$];

    // Floor square root, one result bit at a time from the top
    function automatic longint floor_sqrt(input longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // One tick: slew the beam, ramp the power, return the new outputs
    function automatic beam_result_t advance_beam(input logic signed [CW-1:0] tx,
                                                  input logic signed [CW-1:0] ty,
                                                  input logic on,
                                                  input logic [TIME_WIDTH-1:0] el);
        longint       dx, dy, ax, ay, d2, root, step, delta, pw, nx, ny;
        logic         moving, reach;
        beam_result_t r;
        dx = longint'(tx) - longint'(pos_x);
        dy = longint'(ty) - longint'(pos_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2 = ax * ax + ay * ay;
        root = floor_sqrt(d2);
        step = (longint'(slew_speed) * longint'(el)) >> TIME_WIDTH;
        moving = d2 >= NEAR_SQ;
        reach = step * step >= d2;

        if (moving) begin
            if (reach || root == 0) begin
                pos_x = tx;
                pos_y = ty;
            end else begin
                // each axis moves its share of the step, truncated toward zero
                nx = ax * step / root;
                ny = ay * step / root;
                nx = longint'(pos_x) + (dx < 0 ? -nx : nx);
                ny = longint'(pos_y) + (dy < 0 ? -ny : ny);
                pos_x = nx[CW-1:0];
                pos_y = ny[CW-1:0];
            end
        end

        // power ramps toward full while on, decays toward zero while off
        pw = longint'(power_store);
        if (on) begin
            delta = (longint'(ramp_up_rate) * longint'(el)) >> TIME_WIDTH;
            pw = pw + delta;
            if (pw > POWER_FULL)
                pw = POWER_FULL;
        end else begin
            delta = (longint'(ramp_down_rate) * longint'(el)) >> TIME_WIDTH;
            pw = delta >= pw ? 0 : pw - delta;
        end
        power_store = pw[POWER_WIDTH-1:0];

        r.beam_x = pos_x;
        r.beam_y = pos_y;
        r.moving = moving;
        r.power_level = power_store;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
            flag_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    // Monitor: register writes, result transactions, input transactions
    always @(posedge aclk) begin
        beam_result_t           want;
        logic signed [CW-1:0]   got_x;
        logic signed [CW-1:0]   got_y;
        logic [POWER_WIDTH-1:0] got_power;
        logic [63:0]            got_pad;
        if (!aresetn) begin
            slew_speed = '0;
            ramp_up_rate = '0;
            ramp_down_rate = '0;
            pos_x = '0;
            pos_y = '0;
            power_store = '0;
            pending_beams.delete();
            mismatches = 0;
            beams_pending = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SLEW_SPEED: slew_speed = cfg_wr_data[SPEED_WIDTH-1:0];
                    CFG_RAMP_UP:    ramp_up_rate = cfg_wr_data[RATE_WIDTH-1:0];
                    CFG_RAMP_DOWN:  ramp_down_rate = cfg_wr_data[RATE_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got_x = m_tdata[0 +: CW];
                got_y = m_tdata[CW +: CW];
                got_power = m_tdata[2*CW +: POWER_WIDTH];
                got_pad = 64'(m_tdata >> (2*CW + POWER_WIDTH));
                if (pending_beams.size() == 0) begin
                    flag_error($sformatf("result transaction with none expected: x=%0d y=%0d",
                                         got_x, got_y));
                end else begin
                    want = pending_beams.pop_front();
                    check_field("beam_x", want.beam_x, got_x);
                    check_field("beam_y", want.beam_y, got_y);
                    check_field("moving", {63'd0, want.moving}, {63'd0, m_tuser});
                    check_field("power_level", 64'(want.power_level), 64'(got_power));
                    check_field("tdata padding", 64'd0, got_pad);
                end
            end

            if (s_tvalid && s_tready)
                pending_beams.push_back(advance_beam($signed(s_tdata[0 +: CW]),
                                                     $signed(s_tdata[CW +: CW]),
                                                     s_tuser,
                                                     s_tdata[2*CW +: TIME_WIDTH]));

            beams_pending = pending_beams.size();
        end
    end

endmodule

### sim/vector_beam_slew_and_power_ramp_tb.sv
// Testbench top: clock, reset, tick stimulus, register writes and verdict.
`timescale 1ns / 1ps

module vector_beam_slew_and_power_ramp_tb;
    import vbsp_pkg::*;

    localparam int CW   = 20;
    localparam int FB   = 8;
    localparam int S_W  = ((2*CW+16+7)/8)*8;
    localparam int M_W  = ((2*CW+15+7)/8)*8;
    localparam int CMAX = (1 << (CW-1)) - 1;
    localparam int CMIN = -(1 << (CW-1));

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic [S_W-1:0]            s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [M_W-1:0]            m_tdata;
    logic                      m_tuser;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wr_data = '0;

    int mismatches;
    int beams_pending;
    int send_idle_pct = 9;
    int recv_idle_pct = 63;
    int last_x = 0;
    int last_y = 0;
    bit beam_on_q = 1'b0;

    vector_beam_slew_and_power_ramp #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FB)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    vbsp_beam_checker #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FB)
    ) i_beam_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .beams_pending (beams_pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // One tick transaction, with random idle cycles ahead of it
    task automatic send_tick(input int tx, input int ty, input bit on, input int el);
        logic [S_W-1:0] word;
        word = '0;
        word[0 +: CW] = tx[CW-1:0];
        word[CW +: CW] = ty[CW-1:0];
        word[2*CW +: TIME_WIDTH] = el[TIME_WIDTH-1:0];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= word;
        s_tuser <= on;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        last_x = tx;
        last_y = ty;
    endtask

    // Hold off the input until every predicted result has been returned
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beams_pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= value[CFG_DATA_WIDTH-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned speed, input int unsigned up,
                              input int unsigned down);
        wait_drained();
        write_reg(CFG_SLEW_SPEED, speed);
        write_reg(CFG_RAMP_UP, up);
        write_reg(CFG_RAMP_DOWN, down);
    endtask

    function automatic int clamp_coord(input int v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    // Random ticks: mostly targets near the last one so the beam settles,
    // snaps and hovers around the 3 pixel threshold; some far jumps
    task automatic run_random(input int count);
        int r, tx, ty, el;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                tx = int'($urandom_range(0, (1 << CW) - 1)) + CMIN;
                ty = int'($urandom_range(0, (1 << CW) - 1)) + CMIN;
            end else if (r < 50) begin
                tx = clamp_coord(last_x + int'($urandom_range(0, 4095)) - 2048);
                ty = clamp_coord(last_y + int'($urandom_range(0, 4095)) - 2048);
            end else if (r < 80) begin
                tx = clamp_coord(last_x + int'($urandom_range(0, 2047)) - 1024);
                ty = clamp_coord(last_y + int'($urandom_range(0, 2047)) - 1024);
            end else begin
                tx = last_x;
                ty = last_y;
            end

            r = $urandom_range(0, 99);
            if (r < 25)
                el = $urandom_range(0, 65535);
            else if (r < 75)
                el = $urandom_range(0, 4095);
            else if (r < 85)
                el = 0;
            else
                el = 65535 - $urandom_range(0, 3);

            if ($urandom_range(0, 99) < 12)
                beam_on_q = ~beam_on_q;

            if (i == count / 2 || $urandom_range(0, 149) == 0)
                wait_drained();
            send_tick(tx, ty, beam_on_q, el);
        end
    endtask

    // Stimulus and verdict
    initial begin
        int guard;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: thresholds, exact reach, extremes, zero step, power limits
        set_config(12800, 25600, 25600);
        send_tick(0, 0, 1'b0, 0);
        send_tick(767, 0, 1'b1, 65535);
        send_tick(768, 0, 1'b1, 65535);
        send_tick(CMIN, CMIN, 1'b0, 1024);
        send_tick(CMAX, CMAX, 1'b0, 65535);
        send_tick(CMAX, CMIN, 1'b0, 0);
        send_tick(-300, 500, 1'b1, 40000);
        set_config(24'hFFFFFF, 18'h3FFFF, 18'h3FFFF);
        send_tick(CMIN, CMAX, 1'b0, 65535);
        send_tick(CMIN, CMAX, 1'b1, 65535);
        send_tick(0, 0, 1'b0, 65535);
        set_config(65536, 0, 0);
        send_tick(768, 0, 1'b1, 768);
        send_tick(1537, 0, 1'b0, 768);
        send_tick(1000, 700, 1'b1, 300);
        send_tick(-1000, -700, 1'b0, 65535);
        send_tick(-1000, -700, 1'b1, 65535);
        set_config(0, 1000, 1000);
        send_tick(CMAX, 0, 1'b1, 65535);
        send_tick(CMAX, 0, 1'b0, 65535);
        send_tick(-2, 3, 1'b0, 1);

        // Random phases with different idle patterns and settings
        set_config(1 << 20, 12800, 3000);
        run_random(550);

        send_idle_pct = 63;
        recv_idle_pct = 9;
        set_config($urandom_range(4096, 1 << 22), $urandom_range(0, 262143),
                   $urandom_range(0, 262143));
        run_random(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(24'hFFFFFF, 18'h3FFFF, 18'h3FFFF);
        run_random(275);
        set_config($urandom_range(1 << 16, 1 << 19), 25600, 512);
        run_random(275);

        // Drain with a bound, then leave room for any stray result
        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (beams_pending != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (100) @(posedge aclk);

        if (mismatches == 0 && beams_pending == 0) begin
            $display("** vector_beam_slew_and_power_ramp: PASSED **");
        end else begin
            $display("** vector_beam_slew_and_power_ramp: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("** vector_beam_slew_and_power_ramp: FAILED **");
        $finish;
    end

endmodule

### vector_beam_slew_and_power_ramp.f
sv/vbsp_pkg.sv
sv/vbsp_sqdiv.sv
sv/vector_beam_slew_and_power_ramp.sv
sim/vbsp_beam_checker.sv
sim/vector_beam_slew_and_power_ramp_tb.sv
